### hw/rtl/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and constants of the tree-walk code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htd_pkg;

  localparam int unsigned NODE_COUNT_DEF = 512;
  localparam int unsigned CODE_BITS_DEF  = 32;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned LIMIT_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_BIT_LIMIT = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DECODE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_LOAD,
    S_INS_ERR,
    S_REFRESH,
    S_REFRESH_LD,
    S_DEC_CHK,
    S_DEC_ERR
  } state_e;

  // status of the code bit shifter
  typedef struct packed {
    logic aligned;  // leading pad shifted out, msb is the next code bit
    logic empty;    // all code bits consumed
    logic msb;      // next code bit
  } code_stat_t;

endpackage

`default_nettype wire

### hw/rtl/htd_node_ram.sv
// ----------------------------------------------------------------------------
// htd_node_ram
// Node store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_node_ram #(
  parameter int unsigned DEPTH  = htd_pkg::NODE_COUNT_DEF,
  parameter int unsigned ADDR_W = $clog2(htd_pkg::NODE_COUNT_DEF),
  parameter int unsigned DATA_W = 2 * $clog2(htd_pkg::NODE_COUNT_DEF) + htd_pkg::SYM_W
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/htd_code_sreg.sv
// ----------------------------------------------------------------------------
// htd_code_sreg
// Code bit shifter: left-aligns an insert code one bit per cycle, then hands
// out its bits first bit first, one per shift request.
// ----------------------------------------------------------------------------
`default_nettype none

module htd_code_sreg #(
  parameter int unsigned CODE_BITS = htd_pkg::CODE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        load_i,
  input  wire logic                        shift_i,
  input  wire logic [htd_pkg::VALUE_W-1:0] value_i,
  input  wire logic [htd_pkg::LEN_W-1:0]   length_i,
  output htd_pkg::code_stat_t              stat_o
);

  localparam int unsigned CW = $clog2(CODE_BITS + 1);
  localparam logic [6:0] CodeBits7 = 7'(CODE_BITS);

  logic [CODE_BITS-1:0] sr_q, sr_d;
  logic [CW-1:0]        pad_q, pad_d;
  logic [CW-1:0]        left_q, left_d;
  logic [6:0]           len_ext;
  logic [6:0]           len_sat;
  logic [63:0]          value_ext;

  assign value_ext = 64'(value_i);
  assign len_ext   = 7'(length_i);
  assign len_sat   = (len_ext > CodeBits7) ? CodeBits7 : len_ext;

  always_comb begin
    sr_d   = sr_q;
    pad_d  = pad_q;
    left_d = left_q;
    if (load_i) begin
      sr_d   = value_ext[CODE_BITS-1:0];
      pad_d  = CW'(CodeBits7 - len_sat);
      left_d = CW'(len_sat);
    end else if (pad_q != '0) begin
      sr_d  = sr_q << 1;
      pad_d = pad_q - CW'(1);
    end else if (shift_i && (left_q != '0)) begin
      sr_d   = sr_q << 1;
      left_d = left_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q  <= '0;
      left_q <= '0;
    end else begin
      pad_q  <= pad_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
  end

  assign stat_o.aligned = (pad_q == '0);
  assign stat_o.empty   = (left_q == '0);
  assign stat_o.msb     = sr_q[CODE_BITS-1];

endmodule

`default_nettype wire

### hw/rtl/huffman_tree_decoder_unit.sv
// Decode: per coded bit, an accept step, then the node RAM read and leaf check in
//   S_DEC_CHK; a leaf or error result is registered once the result channel is free.
// Insert: after alignment, per code bit creates a node or reads one via S_INS_LOAD,
//   writes the leaf (S_INS_ERR when the store runs full), then reloads the walk.
// Clear: empties the tree, rewinds the walk. One request in work at a time. Reset:
//   root, walk, bit counter and bit_limit zero, next_free 1; RAM live only below it.
// ----------------------------------------------------------------------------
// huffman_tree_decoder_unit
// Bit-serial code tree decoder with insert/clear commands and an APB register.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_decoder_unit #(
  parameter int unsigned NODE_COUNT = htd_pkg::NODE_COUNT_DEF,
  parameter int unsigned CODE_BITS  = htd_pkg::CODE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [htd_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [htd_pkg::SYM_W-1:0]   symbol_i,
  input  wire logic [htd_pkg::VALUE_W-1:0] code_value_i,
  input  wire logic [htd_pkg::LEN_W-1:0]   code_length_i,
  input  wire logic                        bit_value_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [htd_pkg::SYM_W-1:0]   decoded_symbol_o,
  output logic                             error_o,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int unsigned NW = $clog2(NODE_COUNT);

  typedef struct packed {
    logic [NW-1:0]                zero;
    logic [NW-1:0]                one;
    logic [htd_pkg::SYM_W-1:0]    sym;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  htd_pkg::state_e state_q, state_d;

  logic [NW:0]                   next_free_q, next_free_d;
  logic [NW-1:0]                 cur_q, cur_d;
  logic [NW-1:0]                 node_q, node_d;
  logic [htd_pkg::LIMIT_W-1:0]   bits_q, bits_d;
  logic [htd_pkg::LIMIT_W-1:0]   limit_q;
  node_t                         root_q, root_d;
  node_t                         c_q, c_d;     // entry of cur_q when cur_q is not root
  node_t                         w_q, w_d;     // entry of node_q during insert
  logic [htd_pkg::SYM_W-1:0]     sym_q, sym_d;
  logic                          out_valid_q, out_valid_d;
  logic [htd_pkg::SYM_W-1:0]     out_sym_q, out_sym_d;
  logic                          out_err_q, out_err_d;

  logic                          ram_we;
  logic [NW-1:0]                 ram_waddr;
  logic [NODE_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [NW-1:0]                 ram_raddr;
  logic [NODE_W-1:0]             ram_rdata;
  node_t                         rd;

  logic                          sh_load;
  logic                          sh_shift;
  htd_pkg::code_stat_t           sh_st;

  logic                          cfg_wr;
  logic                          out_free;
  node_t                         cur_ent;
  logic [NW-1:0]                 dec_link;
  logic [NW-1:0]                 ins_link;
  logic [NW-1:0]                 fresh;
  logic                          store_full;
  node_t                         linked;
  logic                          wr_en;
  node_t                         wr_data;

  htd_node_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (NW),
    .DATA_W (NODE_W)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  htd_code_sreg #(
    .CODE_BITS (CODE_BITS)
  ) u_code_sreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (sh_load),
    .shift_i  (sh_shift),
    .value_i  (code_value_i),
    .length_i (code_length_i),
    .stat_o   (sh_st)
  );

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == htd_pkg::REG_BIT_LIMIT);
  assign prdata = (paddr[2] == htd_pkg::REG_BIT_LIMIT) ? limit_q : '0;

  assign rd         = node_t'(ram_rdata);
  assign out_free   = !out_valid_q || out_ready_i;
  assign cur_ent    = (cur_q == '0) ? root_q : c_q;
  assign dec_link   = bit_value_i ? cur_ent.one : cur_ent.zero;
  assign ins_link   = sh_st.msb ? w_q.one : w_q.zero;
  assign fresh      = next_free_q[NW-1:0];
  assign store_full = (next_free_q == (NW + 1)'(NODE_COUNT));

  always_comb begin
    linked = w_q;
    if (sh_st.msb) begin
      linked.one = fresh;
    end else begin
      linked.zero = fresh;
    end
  end

  assign in_ready_o = (state_q == htd_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    next_free_d = next_free_q;
    cur_d       = cur_q;
    node_d      = node_q;
    bits_d      = bits_q;
    root_d      = root_q;
    c_d         = c_q;
    w_d         = w_q;
    sym_d       = sym_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sym_d   = out_sym_q;
    out_err_d   = out_err_q;
    ram_we      = 1'b0;
    ram_waddr   = node_q;
    ram_wdata   = w_q;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    sh_load     = 1'b0;
    sh_shift    = 1'b0;
    wr_en       = 1'b0;
    wr_data     = w_q;

    unique case (state_q)
      htd_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (htd_pkg::cmd_e'(cmd_i))
            htd_pkg::CMD_CLEAR: begin
              root_d      = '0;
              next_free_d = (NW + 1)'(1);
              cur_d       = '0;
              bits_d      = '0;
            end
            htd_pkg::CMD_INSERT: begin
              sh_load = 1'b1;
              sym_d   = symbol_i;
              node_d  = '0;
              w_d     = root_q;
              state_d = htd_pkg::S_INS_STEP;
            end
            htd_pkg::CMD_DECODE: begin
              if (bits_q < limit_q) begin
                bits_d = bits_q + 1'b1;
                if (dec_link == '0) begin
                  cur_d   = '0;
                  state_d = htd_pkg::S_DEC_ERR;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = dec_link;
                  node_d    = dec_link;
                  state_d   = htd_pkg::S_DEC_CHK;
                end
              end
            end
            default: ;
          endcase
        end
      end

      htd_pkg::S_INS_STEP: begin
        if (sh_st.aligned) begin
          if (sh_st.empty) begin
            wr_en       = 1'b1;
            wr_data     = w_q;
            wr_data.sym = sym_q;
            state_d     = htd_pkg::S_REFRESH;
          end else if (ins_link == '0) begin
            // write back too: a node created on the last step is not in RAM yet
            wr_en = 1'b1;
            if (store_full) begin
              wr_data = w_q;
              state_d = htd_pkg::S_INS_ERR;
            end else begin
              wr_data     = linked;
              node_d      = fresh;
              w_d         = '0;
              next_free_d = next_free_q + 1'b1;
              sh_shift    = 1'b1;
            end
          end else begin
            sh_shift  = 1'b1;
            node_d    = ins_link;
            ram_re    = 1'b1;
            ram_raddr = ins_link;
            state_d   = htd_pkg::S_INS_LOAD;
          end
        end
      end

      htd_pkg::S_INS_LOAD: begin
        w_d     = rd;
        state_d = htd_pkg::S_INS_STEP;
      end

      htd_pkg::S_INS_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = '0;
          out_err_d   = 1'b1;
          state_d     = htd_pkg::S_REFRESH;
        end
      end

      // the insert may have touched the node the decode walk sits on
      htd_pkg::S_REFRESH: begin
        if (cur_q == '0) begin
          state_d = htd_pkg::S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_q;
          state_d   = htd_pkg::S_REFRESH_LD;
        end
      end

      htd_pkg::S_REFRESH_LD: begin
        c_d     = rd;
        state_d = htd_pkg::S_IDLE;
      end

      htd_pkg::S_DEC_CHK: begin
        if ((rd.zero == '0) && (rd.one == '0)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_sym_d   = rd.sym;
            out_err_d   = 1'b0;
            cur_d       = '0;
            state_d     = htd_pkg::S_IDLE;
          end
        end else begin
          cur_d   = node_q;
          c_d     = rd;
          state_d = htd_pkg::S_IDLE;
        end
      end

      htd_pkg::S_DEC_ERR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = '0;
          out_err_d   = 1'b1;
          state_d     = htd_pkg::S_IDLE;
        end
      end

      default: state_d = htd_pkg::S_IDLE;
    endcase

    // root lives in flops, the rest of the tree in RAM
    if (wr_en) begin
      if (node_q == '0) begin
        root_d = wr_data;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = node_q;
        ram_wdata = wr_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= htd_pkg::S_IDLE;
      next_free_q <= (NW + 1)'(1);
      cur_q       <= '0;
      bits_q      <= '0;
      limit_q     <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      cur_q       <= cur_d;
      bits_q      <= bits_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        limit_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q    <= node_d;
    c_q       <= c_d;
    w_q       <= w_d;
    sym_q     <= sym_d;
    out_sym_q <= out_sym_d;
    out_err_q <= out_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign decoded_symbol_o = out_sym_q;
  assign error_o          = out_err_q;

endmodule

`default_nettype wire
